// File: rtl/uv_sphere_cell_tessellator_macros.svh
// assertion macros for the uv sphere cell tessellator checker
// needs clk and rst in the scope where a macro is used
`ifndef UV_SPHERE_CELL_TESSELLATOR_MACROS_SVH
`define UV_SPHERE_CELL_TESSELLATOR_MACROS_SVH

// checked only outside reset
`define UST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define UST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ust_pkg.sv
// shared types and constants of the uv sphere cell tessellator
// no dependencies
`default_nettype none

package ust_pkg;

  // octant angle and series constants, Q30
  localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  // pipelined divider depths
  localparam int T_QW   = 30;
  localparam int TEX_QW = 17;

  // registers from the angle input to the trig result
  localparam int TRIG_LAT = 47;

  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;

  // floor(x/d) = (x*rcp) >> shift, exact for x below 2^30
  localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
    32'd1249445032, 32'd1908874354, 32'd1636178018, 32'd1717986919, 32'd1431655766};
  localparam int SIN_SHIFT [SIN_STEPS] = '{37, 37, 36, 35, 33};
  localparam logic [31:0] COS_RCP [COS_STEPS] = '{
    32'd2082408386, 32'd1527099484, 32'd1227133514, 32'd1145324613, 32'd1431655766,
    32'd1073741824};
  localparam int COS_SHIFT [COS_STEPS] = '{38, 37, 36, 35, 34, 31};

  localparam logic [2:0] SLOT_FIRST = 3'd0;
  localparam logic [2:0] SLOT_LAST  = 3'd5;

  // per slot latitude and longitude offsets: a,b,c,b,d,c
  localparam logic [7:0] SLOT_DLAT = 8'b0001_1010;
  localparam logic [7:0] SLOT_DLON = 8'b0011_0100;

  localparam logic [8:0] SUBDIV_RESET = 9'd16;

  typedef struct packed {
    logic [30:0] sin_mag;
    logic        sin_neg;
    logic [30:0] cos_mag;
    logic        cos_neg;
  } trig_t;

  typedef struct packed {
    logic [2:0] slot;
    logic       last;
    logic       bad;
  } vtag_t;

endpackage

`default_nettype wire

// File: rtl/ust_ifs.sv
// valid/ready channel interfaces of the uv sphere cell tessellator
// no dependencies
`default_nettype none

interface ust_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] lat_index;
  logic [7:0] lon_index;

  modport source (output valid, lat_index, lon_index, input ready);
  modport sink   (input valid, lat_index, lon_index, output ready);
endinterface

interface ust_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic        [16:0] tex_u;
  logic        [16:0] tex_v;
  logic        [2:0]  vertex_slot;
  logic               bad_index;
  logic               last;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_slot, bad_index,
                  last, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_slot, bad_index,
                  last, output ready);
endinterface

`default_nettype wire

// File: rtl/ust_div.sv
// pipelined restoring divider, one quotient bit per stage; no deps
// user holds divisor stable while words are in flight; not enforced
`default_nettype none

module ust_div #(
  parameter int NW = 9,
  parameter int DW = 40,
  parameter int QW = 30
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] den,
  input  wire logic [DW-1:0] num,
  output logic      [QW-1:0] quo
);

  logic [NW-1:0] rem [QW];
  logic [QW-1:0] wrk [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [QW-1:0] wrk_in;
    logic [NW:0]   trial;

    if (i == 0) begin : g_first
      assign rem_in = NW'(num >> QW);
      assign wrk_in = num[QW-1:0];
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign wrk_in = wrk[i-1];
    end

    assign trial = {rem_in, wrk_in[QW-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, den}) begin
          rem[i] <= NW'(trial - {1'b0, den});
          wrk[i] <= {wrk_in[QW-2:0], 1'b1};
        end else begin
          rem[i] <= trial[NW-1:0];
          wrk[i] <= {wrk_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = wrk[QW-1];

endmodule

`default_nettype wire

// File: rtl/ust_trig.sv
// sine and cosine of an angle given in quarter steps of a turn over n
// depends on ust_pkg and ust_div
`default_nettype none

module ust_trig #(
  parameter int NW = 9
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [NW-1:0]   n,
  input  wire logic [NW+1:0]   m,
  output ust_pkg::trig_t       res
);

  localparam int MW = NW + 2;
  localparam int PW = 31 + NW;
  localparam int SER = 2 * ust_pkg::COS_STEPS + 1;

  typedef struct packed {
    logic       swap;
    logic [1:0] quad;
  } octant_t;

  // quadrant split
  logic [MW-1:0] n1, n2, n3;
  logic [NW-1:0] r1;
  logic [1:0]    quad1;

  assign n1 = MW'(n);
  assign n2 = n1 << 1;
  assign n3 = n1 + n2;

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (m >= n3) begin
        quad1 <= 2'd3;
        r1    <= NW'(m - n3);
      end else if (m >= n2) begin
        quad1 <= 2'd2;
        r1    <= NW'(m - n2);
      end else if (m >= n1) begin
        quad1 <= 2'd1;
        r1    <= NW'(m - n1);
      end else begin
        quad1 <= 2'd0;
        r1    <= NW'(m);
      end
    end
  end

  // fold into the first octant
  logic          swap_c;
  logic [NW-1:0] s2;
  octant_t       oct2;

  assign swap_c = ({1'b0, r1} << 1) > {1'b0, n};

  always_ff @(posedge clk) begin
    if (en) begin
      s2        <= swap_c ? n - r1 : r1;
      oct2.swap <= swap_c;
      oct2.quad <= quad1;
    end
  end

  // t = floor(pi/2 * s / n)
  logic [PW-1:0] prod3;
  octant_t       oct_d [ust_pkg::T_QW + 1];
  logic [29:0]   t_quo;

  always_ff @(posedge clk) begin
    if (en) begin
      prod3    <= PW'(ust_pkg::PI_HALF_Q30) * PW'(s2);
      oct_d[0] <= oct2;
      for (int i = 1; i <= ust_pkg::T_QW; i++) oct_d[i] <= oct_d[i-1];
    end
  end

  ust_div #(.NW(NW), .DW(PW), .QW(ust_pkg::T_QW)) u_tdiv (
    .clk (clk),
    .en  (en),
    .den (n),
    .num (prod3),
    .quo (t_quo)
  );

  // t, t^2 and octant carried along the series stages
  logic [29:0] tt   [SER];
  logic [29:0] t2p  [SER];
  octant_t     octp [SER];
  logic [59:0] tsq;

  assign tsq = 60'(t_quo) * 60'(t_quo);

  always_ff @(posedge clk) begin
    if (en) begin
      tt[0]   <= t_quo;
      t2p[0]  <= tsq[59:30];
      octp[0] <= oct_d[ust_pkg::T_QW];
      for (int i = 1; i < SER; i++) begin
        tt[i]   <= tt[i-1];
        t2p[i]  <= t2p[i-1];
        octp[i] <= octp[i-1];
      end
    end
  end

  // cosine horner series, two registers per step
  logic [29:0] xc [ust_pkg::COS_STEPS];
  logic [61:0] yc [ust_pkg::COS_STEPS];

  for (genvar k = 0; k < ust_pkg::COS_STEPS; k++) begin : g_cos
    logic [30:0] acc;
    logic [60:0] px;

    if (k == 0) begin : g_one
      assign acc = ust_pkg::Q30_ONE;
    end else begin : g_acc
      assign acc = ust_pkg::Q30_ONE - 31'(yc[k-1] >> ust_pkg::COS_SHIFT[k-1]);
    end

    assign px = 61'(t2p[2*k]) * 61'(acc);

    always_ff @(posedge clk) begin
      if (en) begin
        xc[k] <= px[59:30];
        yc[k] <= 62'(xc[k]) * 62'(ust_pkg::COS_RCP[k]);
      end
    end
  end

  // sine horner series
  logic [29:0] xs [ust_pkg::SIN_STEPS];
  logic [61:0] ys [ust_pkg::SIN_STEPS];

  for (genvar k = 0; k < ust_pkg::SIN_STEPS; k++) begin : g_sin
    logic [30:0] acc;
    logic [60:0] px;

    if (k == 0) begin : g_one
      assign acc = ust_pkg::Q30_ONE;
    end else begin : g_acc
      assign acc = ust_pkg::Q30_ONE - 31'(ys[k-1] >> ust_pkg::SIN_SHIFT[k-1]);
    end

    assign px = 61'(t2p[2*k]) * 61'(acc);

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= px[59:30];
        ys[k] <= 62'(xs[k]) * 62'(ust_pkg::SIN_RCP[k]);
      end
    end
  end

  localparam int SL = ust_pkg::SIN_STEPS - 1;
  localparam int CL = ust_pkg::COS_STEPS - 1;

  logic [30:0] sin_acc, cs;
  logic [61:0] psn;
  logic [30:0] sn_a, sn_b;

  assign sin_acc = ust_pkg::Q30_ONE - 31'(ys[SL] >> ust_pkg::SIN_SHIFT[SL]);
  assign psn     = 62'(tt[2*ust_pkg::SIN_STEPS]) * 62'(sin_acc);
  assign cs      = ust_pkg::Q30_ONE - 31'(yc[CL] >> ust_pkg::COS_SHIFT[CL]);

  always_ff @(posedge clk) begin
    if (en) begin
      sn_a <= psn[60:30];
      sn_b <= sn_a;
    end
  end

  // undo the octant fold and place in the quadrant
  logic [30:0] sv, cv;

  assign sv = octp[SER-1].swap ? cs : sn_b;
  assign cv = octp[SER-1].swap ? sn_b : cs;

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (octp[SER-1].quad)
        2'd0: res <= '{sin_mag: sv, sin_neg: 1'b0, cos_mag: cv, cos_neg: 1'b0};
        2'd1: res <= '{sin_mag: cv, sin_neg: 1'b0, cos_mag: sv, cos_neg: 1'b1};
        2'd2: res <= '{sin_mag: sv, sin_neg: 1'b1, cos_mag: cv, cos_neg: 1'b1};
        default: res <= '{sin_mag: cv, sin_neg: 1'b1, cos_mag: sv, cos_neg: 1'b0};
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/uv_sphere_cell_tessellator.sv
// UV sphere cell tessellator: one latitude/longitude cell word in, six vertex words out
// (a,b,c,b,d,c) with Q1.14 position/normal and Q1.16 texcoords. A cell whose index is
// not below the subdivision count gives a single word with bad_index and last set.
// Rate: one vertex word per cycle while the output is not stalled, the cell being held in
// an input register while its six vertices issue. The first vertex word passes the hold
// register, the issue stage, the numerator register, the trig units, the product register
// and the output register; the trig path is the angle divider (one quotient bit per stage)
// and the sine and cosine series (two registers per term). The whole pipeline stalls
// together only while the output register holds an untaken word; the input register
// still takes a new cell whenever it is empty. subdivisions is written on cfg_we and
// must not change while words are in flight. No clearing pass after reset.
// depends on ust_pkg, ust_ifs, ust_div and ust_trig
`default_nettype none

module uv_sphere_cell_tessellator #(
  parameter int MAX_SUBDIVISIONS = 256,
  parameter int COORD_FRAC_BITS  = 14
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [8:0] cfg_wdata,
  ust_cell_if.sink        cell_idx,
  ust_vtx_if.source       vtx
);

  localparam int NW = $clog2(MAX_SUBDIVISIONS + 1);
  localparam int MW = NW + 2;
  localparam int KW = NW + 3;
  localparam int TW = NW + 17;
  localparam int PL = ust_pkg::TRIG_LAT + 1;
  localparam int TEX_DLY = ust_pkg::TRIG_LAT - ust_pkg::TEX_QW;
  localparam logic [60:0] RND = 61'(1) << (59 - COORD_FRAC_BITS);

  // subdivision register; n is its value saturated to the supported maximum
  logic [8:0]    subdivisions;
  logic [NW-1:0] n;

  always_ff @(posedge clk) begin
    if (rst) begin
      subdivisions <= ust_pkg::SUBDIV_RESET;
    end else if (cfg_we) begin
      subdivisions <= cfg_wdata;
    end
  end

  assign n = (32'(subdivisions) > 32'(MAX_SUBDIVISIONS)) ? NW'(MAX_SUBDIVISIONS)
                                                         : NW'(subdivisions);

  // pipeline advance: output register empty or being taken
  logic out_vld;
  logic en;

  assign en = !out_vld || vtx.ready;

  // input hold register and vertex sequencer
  logic       hold_vld;
  logic [7:0] hold_lat, hold_lon;
  logic       hold_bad;
  logic [2:0] cnt;
  logic       issue, issue_done, accept, in_bad;

  assign issue          = hold_vld && en;
  assign issue_done     = issue && (hold_bad || cnt == ust_pkg::SLOT_LAST);
  assign cell_idx.ready = !hold_vld || issue_done;
  assign accept         = cell_idx.valid && cell_idx.ready;
  assign in_bad         = (n == '0) || (32'(cell_idx.lat_index) >= 32'(n))
                          || (32'(cell_idx.lon_index) >= 32'(n));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
      cnt      <= ust_pkg::SLOT_FIRST;
    end else if (accept) begin
      hold_vld <= 1'b1;
      cnt      <= ust_pkg::SLOT_FIRST;
    end else if (issue_done) begin
      hold_vld <= 1'b0;
    end else if (issue) begin
      cnt      <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_lat <= cell_idx.lat_index;
      hold_lon <= cell_idx.lon_index;
      hold_bad <= in_bad;
    end
  end

  // vertex issue stage: grid point of this slot
  logic                vld0;
  logic [8:0]          p0, q0;
  ust_pkg::vtag_t      tag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0       <= 9'(hold_lat) + 9'(ust_pkg::SLOT_DLAT[cnt]);
      q0       <= 9'(hold_lon) + 9'(ust_pkg::SLOT_DLON[cnt]);
      tag0.slot <= hold_bad ? ust_pkg::SLOT_FIRST : cnt;
      tag0.last <= hold_bad || cnt == ust_pkg::SLOT_LAST;
      tag0.bad  <= hold_bad;
    end
  end

  // angle and texcoord numerators
  logic [KW-1:0] k_lat, four_n;
  logic [MW-1:0] m_lat1, m_lon1;
  logic [TW-1:0] udiv1, vdiv1;

  assign four_n = KW'(n) << 2;
  assign k_lat  = (KW'(p0) << 1) + KW'(n) + (KW'(n) << 1);

  always_ff @(posedge clk) begin
    if (en) begin
      m_lat1 <= (k_lat >= four_n) ? MW'(k_lat - four_n) : MW'(k_lat);
      m_lon1 <= (32'(q0) == 32'(n)) ? '0 : MW'(q0) << 2;
      udiv1  <= (TW'(q0) << 16) + TW'(n >> 1);
      vdiv1  <= ((TW'(n) - TW'(p0)) << 16) + TW'(n >> 1);
    end
  end

  // valid and tag follow the trig pipeline
  logic           pl_vld [PL];
  ust_pkg::vtag_t pl_tag [PL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PL; i++) pl_vld[i] <= 1'b0;
    end else if (en) begin
      pl_vld[0] <= vld0;
      for (int i = 1; i < PL; i++) pl_vld[i] <= pl_vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_tag[0] <= tag0;
      for (int i = 1; i < PL; i++) pl_tag[i] <= pl_tag[i-1];
    end
  end

  // latitude and longitude trig units
  ust_pkg::trig_t lat_res, lon_res;

  ust_trig #(.NW(NW)) u_lat (
    .clk (clk),
    .en  (en),
    .n   (n),
    .m   (m_lat1),
    .res (lat_res)
  );

  ust_trig #(.NW(NW)) u_lon (
    .clk (clk),
    .en  (en),
    .n   (n),
    .m   (m_lon1),
    .res (lon_res)
  );

  // texcoord dividers, delayed to line up with the trig results
  logic [16:0] u_quo, v_quo;
  logic [16:0] u_d [TEX_DLY];
  logic [16:0] v_d [TEX_DLY];

  ust_div #(.NW(NW), .DW(TW), .QW(ust_pkg::TEX_QW)) u_udiv (
    .clk (clk),
    .en  (en),
    .den (n),
    .num (udiv1),
    .quo (u_quo)
  );

  ust_div #(.NW(NW), .DW(TW), .QW(ust_pkg::TEX_QW)) u_vdiv (
    .clk (clk),
    .en  (en),
    .den (n),
    .num (vdiv1),
    .quo (v_quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      u_d[0] <= u_quo;
      v_d[0] <= v_quo;
      for (int i = 1; i < TEX_DLY; i++) begin
        u_d[i] <= u_d[i-1];
        v_d[i] <= v_d[i-1];
      end
    end
  end

  // position products, Q60 magnitudes
  logic           vld_p;
  ust_pkg::vtag_t tag_p;
  logic [61:0]    xm_p, zm_p;
  logic [30:0]    ym_p;
  logic           xn_p, yn_p, zn_p;
  logic [16:0]    u_p, v_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= pl_vld[PL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_p <= pl_tag[PL-1];
      xm_p  <= 62'(lat_res.cos_mag) * 62'(lon_res.cos_mag);
      zm_p  <= 62'(lat_res.cos_mag) * 62'(lon_res.sin_mag);
      ym_p  <= lat_res.sin_mag;
      xn_p  <= lat_res.cos_neg ^ lon_res.cos_neg;
      zn_p  <= lat_res.cos_neg ^ lon_res.sin_neg;
      yn_p  <= lat_res.sin_neg;
      u_p   <= u_d[TEX_DLY-1];
      v_p   <= v_d[TEX_DLY-1];
    end
  end

  // round half away from zero, then sign and wrap to 16 bits
  function automatic logic [15:0] to_coord(input logic [60:0] mag, input logic neg);
    logic [60:0] r;
    r = (mag + RND) >> (60 - COORD_FRAC_BITS);
    if (neg) r = 61'(0) - r;
    return r[15:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vtx.vertex_slot <= tag_p.slot;
      vtx.last        <= tag_p.last;
      vtx.bad_index   <= tag_p.bad;
      if (tag_p.bad) begin
        vtx.pos_x <= '0;
        vtx.pos_y <= '0;
        vtx.pos_z <= '0;
        vtx.tex_u <= '0;
        vtx.tex_v <= '0;
      end else begin
        vtx.pos_x <= to_coord(xm_p[60:0], xn_p);
        vtx.pos_y <= to_coord({ym_p, 30'b0}, yn_p);
        vtx.pos_z <= to_coord(zm_p[60:0], zn_p);
        vtx.tex_u <= u_p;
        vtx.tex_v <= v_p;
      end
    end
  end

  assign vtx.valid = out_vld;

endmodule

`default_nettype wire

// File: rtl/ust_checker.sv
// port level checks of the uv sphere cell tessellator, bound to the top level
// depends on ust_pkg and uv_sphere_cell_tessellator_macros.svh
`default_nettype none
`include "uv_sphere_cell_tessellator_macros.svh"

module ust_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        vtx_valid,
  input wire logic        vtx_ready,
  input wire logic [15:0] pos_x,
  input wire logic [15:0] pos_y,
  input wire logic [15:0] pos_z,
  input wire logic [16:0] tex_u,
  input wire logic [16:0] tex_v,
  input wire logic [2:0]  vertex_slot,
  input wire logic        bad_index,
  input wire logic        last
);

  // a stalled word holds
  `UST_ASSERT(a_hold, vtx_valid && !vtx_ready |=> vtx_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z) && $stable(tex_u) && $stable(tex_v) && $stable(vertex_slot) && $stable(last), "stalled vertex word changed")

  // a flagged cell gives one zeroed word
  `UST_ASSERT(a_bad, vtx_valid && bad_index |-> last && pos_x == 16'd0 && pos_y == 16'd0 && pos_z == 16'd0 && tex_u == 17'd0 && tex_v == 17'd0 && vertex_slot == ust_pkg::SLOT_FIRST, "bad cell word not clean")

  // last marks the final slot of a good cell
  `UST_ASSERT(a_last, vtx_valid && !bad_index |-> last == (vertex_slot == ust_pkg::SLOT_LAST), "last flag out of place")

  // vertices of one cell leave back to back in slot order
  `UST_ASSERT(a_seq, vtx_valid && vtx_ready && !last |=> vtx_valid && !bad_index && vertex_slot == $past(vertex_slot) + 3'd1, "vertex sequence broken")

  // texcoords stay within one
  `UST_ASSERT(a_tex, vtx_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536, "texcoord above one")

endmodule

bind uv_sphere_cell_tessellator ust_checker u_ust_checker (
  .clk         (clk),
  .rst         (rst),
  .vtx_valid   (vtx.valid),
  .vtx_ready   (vtx.ready),
  .pos_x       (vtx.pos_x),
  .pos_y       (vtx.pos_y),
  .pos_z       (vtx.pos_z),
  .tex_u       (vtx.tex_u),
  .tex_v       (vtx.tex_v),
  .vertex_slot (vtx.vertex_slot),
  .bad_index   (vtx.bad_index),
  .last        (vtx.last)
);

`default_nettype wire
